/* sv/boqt_pkg.sv */
// Shared codes, command and status types for the box overlap query table.
`timescale 1ns / 1ps
`default_nettype none
package boqt_pkg;

   localparam int IN_BITS   = 16;
   localparam int SLOT_BITS = 5;

   // Request function codes
   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_QUERY  = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;
   localparam logic [1:0] FUNC_CLEAR  = 2'd3;

   // Response status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_FULL = 2'd1;
   localparam logic [1:0] STAT_NONE = 2'd2;

   typedef enum logic [1:0] {
      EMIT_SLOT,
      EMIT_PEND,
      EMIT_FULL,
      EMIT_NONE
   } emit_sel_type;

   typedef struct packed {
      logic         load_query;
      logic         wr_box;
      logic         rd_en;
      logic         pend_clear;
      logic         pend_load;
      logic         emit;
      emit_sel_type emit_sel;
      logic         emit_last;
   } cmd_type;

   typedef struct packed {
      logic overlap_hit;
      logic cell_hit;
      logic pend_valid;
      logic out_free;
   } stat_type;

   // Sign-extend a 16-bit input coordinate to 32 bits.
   function automatic logic [31:0] sext_in(input logic [IN_BITS-1:0] v);
      return {{(32 - IN_BITS){v[IN_BITS-1]}}, v};
   endfunction

endpackage
`default_nettype wire

/* sv/boqt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module boqt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* sv/boqt_datapath.sv */
// Datapath: box storage, query registers, hit compare, pending hit and response register.
`timescale 1ns / 1ps
`default_nettype none
module boqt_datapath #(
   parameter int MAX_BOXES  = 32,
   parameter int COORD_BITS = 16,
   localparam int IDX_BITS = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [boqt_pkg::IN_BITS-1:0]   req_lo_x,
   input  wire logic [boqt_pkg::IN_BITS-1:0]   req_lo_y,
   input  wire logic [boqt_pkg::IN_BITS-1:0]   req_lo_z,
   input  wire logic [boqt_pkg::IN_BITS-1:0]   req_hi_x,
   input  wire logic [boqt_pkg::IN_BITS-1:0]   req_hi_y,
   input  wire logic [boqt_pkg::IN_BITS-1:0]   req_hi_z,
   input  wire boqt_pkg::cmd_type              cmd,
   output boqt_pkg::stat_type                  stat,
   input  wire logic [IDX_BITS-1:0]            wr_addr,
   input  wire logic [IDX_BITS-1:0]            rd_addr,
   input  wire logic [IDX_BITS-1:0]            slot_idx,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [boqt_pkg::SLOT_BITS-1:0]      rsp_slot,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last
);
   import boqt_pkg::*;

   localparam int WORD_BITS = 6 * COORD_BITS;

   logic [31:0] ext_lx, ext_ly, ext_lz, ext_hx, ext_hy, ext_hz;
   logic [WORD_BITS-1:0] in_word;
   logic [WORD_BITS-1:0] rd_word;

   logic [WORD_BITS-1:0] query_ff;

   logic signed [COORD_BITS-1:0] b_lx, b_ly, b_lz, b_hx, b_hy, b_hz;
   logic signed [COORD_BITS-1:0] q_lx, q_ly, q_lz, q_hx, q_hy, q_hz;

   logic                  pend_valid_ff, pend_valid_in;
   logic [IDX_BITS-1:0]   pend_slot_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_BITS-1:0]  rsp_slot_ff;
   logic [1:0]            rsp_status_ff;
   logic                  rsp_last_ff;

   logic [31:0]           slot_wide;
   logic [31:0]           pend_wide;
   logic                  out_free;

   // Wrap each coordinate to the stored width.
   assign ext_lx = sext_in(req_lo_x);
   assign ext_ly = sext_in(req_lo_y);
   assign ext_lz = sext_in(req_lo_z);
   assign ext_hx = sext_in(req_hi_x);
   assign ext_hy = sext_in(req_hi_y);
   assign ext_hz = sext_in(req_hi_z);

   assign in_word = {ext_hz[COORD_BITS-1:0], ext_hy[COORD_BITS-1:0], ext_hx[COORD_BITS-1:0],
                     ext_lz[COORD_BITS-1:0], ext_ly[COORD_BITS-1:0], ext_lx[COORD_BITS-1:0]};

   boqt_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(MAX_BOXES)
   ) u_box_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_box),
      .wr_addr (wr_addr),
      .wr_data (in_word),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign {b_hz, b_hy, b_hx, b_lz, b_ly, b_lx} = rd_word;
   assign {q_hz, q_hy, q_hx, q_lz, q_ly, q_lx} = query_ff;

   // min(bh,qh) > max(bl,ql) on every axis, written as four compares per axis
   always_comb begin
      stat.overlap_hit = (b_hx > q_lx) && (q_hx > b_lx) && (b_hx > b_lx) && (q_hx > q_lx) &&
                         (b_hy > q_ly) && (q_hy > b_ly) && (b_hy > b_ly) && (q_hy > q_ly) &&
                         (b_hz > q_lz) && (q_hz > b_lz) && (b_hz > b_lz) && (q_hz > q_lz);
      stat.cell_hit    = (q_lx >= b_lx) && (q_lx < b_hx) &&
                         (q_ly >= b_ly) && (q_ly < b_hy) &&
                         (q_lz >= b_lz) && (q_lz < b_hz);
      stat.pend_valid  = pend_valid_ff;
      stat.out_free    = out_free;
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign slot_wide = 32'(slot_idx);
   assign pend_wide = 32'(pend_slot_ff);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (cmd.pend_clear) begin
         pend_valid_in = 1'b0;
      end else if (cmd.pend_load) begin
         pend_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (cmd.load_query) begin
         query_ff <= in_word;
      end
      if (cmd.pend_load) begin
         pend_slot_ff <= slot_idx;
      end
      if (cmd.emit) begin
         rsp_last_ff <= cmd.emit_last;
         case (cmd.emit_sel)
            EMIT_SLOT: begin
               rsp_slot_ff   <= slot_wide[SLOT_BITS-1:0];
               rsp_status_ff <= STAT_OK;
            end
            EMIT_PEND: begin
               rsp_slot_ff   <= pend_wide[SLOT_BITS-1:0];
               rsp_status_ff <= STAT_OK;
            end
            EMIT_FULL: begin
               rsp_slot_ff   <= '0;
               rsp_status_ff <= STAT_FULL;
            end
            default: begin
               rsp_slot_ff   <= '0;
               rsp_status_ff <= STAT_NONE;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire

/* sv/boqt_ctrl.sv */
// Controller: request decode, box count and slot-order scan sequencer.
`timescale 1ns / 1ps
`default_nettype none
module boqt_ctrl #(
   parameter int MAX_BOXES = 32,
   localparam int IDX_BITS = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
   localparam int CNT_BITS = $clog2(MAX_BOXES + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_func,
   output boqt_pkg::cmd_type          cmd,
   input  wire boqt_pkg::stat_type    stat,
   output logic [IDX_BITS-1:0]        wr_addr,
   output logic [IDX_BITS-1:0]        rd_addr,
   output logic [IDX_BITS-1:0]        slot_idx
);
   import boqt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [CNT_BITS-1:0]   next_idx_ff, next_idx_in;
   logic [IDX_BITS-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                  lookup_ff, lookup_in;
   logic                  hit;
   logic                  full;

   assign full     = (count_ff >= CNT_BITS'(MAX_BOXES));
   assign hit      = lookup_ff ? stat.cell_hit : stat.overlap_hit;
   assign wr_addr  = count_ff[IDX_BITS-1:0];
   assign slot_idx = (state_ff == ST_IDLE) ? count_ff[IDX_BITS-1:0] : cmp_idx_ff;
   assign req_ready = (state_ff == ST_IDLE) && stat.out_free;

   always_comb begin
      cmd         = '0;
      cmd.emit_sel = EMIT_NONE;
      rd_addr     = next_idx_ff[IDX_BITS-1:0];
      state_in    = state_ff;
      count_in    = count_ff;
      next_idx_in = next_idx_ff;
      cmp_idx_in  = cmp_idx_ff;
      lookup_in   = lookup_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               case (req_func)
                  FUNC_INSERT: begin
                     cmd.emit      = 1'b1;
                     cmd.emit_last = 1'b1;
                     if (full) begin
                        cmd.emit_sel = EMIT_FULL;
                     end else begin
                        cmd.wr_box   = 1'b1;
                        cmd.emit_sel = EMIT_SLOT;
                        count_in     = count_ff + CNT_BITS'(1);
                     end
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     cmd.load_query = 1'b1;
                     cmd.pend_clear = 1'b1;
                     lookup_in      = (req_func == FUNC_LOOKUP);
                     if (count_ff == '0) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_sel  = EMIT_NONE;
                        cmd.emit_last = 1'b1;
                     end else begin
                        cmd.rd_en   = 1'b1;
                        rd_addr     = '0;
                        cmp_idx_in  = '0;
                        next_idx_in = CNT_BITS'(1);
                        state_in    = ST_SCAN;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit && lookup_ff) begin
               // first containing box ends the lookup
               if (stat.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_sel  = EMIT_SLOT;
                  cmd.emit_last = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (!(hit && stat.pend_valid && !stat.out_free)) begin
               // hold each hit back one step so the final one can carry last
               if (hit) begin
                  cmd.pend_load = 1'b1;
                  if (stat.pend_valid) begin
                     cmd.emit     = 1'b1;
                     cmd.emit_sel = EMIT_PEND;
                  end
               end
               if (next_idx_ff < count_ff) begin
                  cmd.rd_en   = 1'b1;
                  cmp_idx_in  = next_idx_ff[IDX_BITS-1:0];
                  next_idx_in = next_idx_ff + CNT_BITS'(1);
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = stat.pend_valid ? EMIT_PEND : EMIT_NONE;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         next_idx_ff <= '0;
         cmp_idx_ff  <= '0;
         lookup_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         next_idx_ff <= next_idx_in;
         cmp_idx_ff  <= cmp_idx_in;
         lookup_ff   <= lookup_in;
      end
   end

endmodule
`default_nettype wire

/* sv/box_overlap_query_table_core.sv */
// Top level of the axis-aligned box overlap query table.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to MAX_BOXES half-open integer boxes in one RAM word per slot. Insert (func 0)
// appends a box and answers its slot, or full; clear (func 3) empties the table and gives
// no beat. Overlap query (func 1) and cell lookup (func 2) walk the stored boxes in
// slot order through the RAM's registered read port, one box per cycle while the
// response side does not stall; a lookup stops at its first hit. Each query hit is
// held back one step so that the final beat carries last; a query or lookup with no
// hit gives one no-match beat. Coordinates are wrapped to COORD_BITS and compared
// signed. A new request is taken only once the scan is done and the response register
// is free.
module box_overlap_query_table_core #(
   parameter int MAX_BOXES  = 32,
   parameter int COORD_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_func,
   input  wire logic [boqt_pkg::IN_BITS-1:0]  req_lo_x,
   input  wire logic [boqt_pkg::IN_BITS-1:0]  req_lo_y,
   input  wire logic [boqt_pkg::IN_BITS-1:0]  req_lo_z,
   input  wire logic [boqt_pkg::IN_BITS-1:0]  req_hi_x,
   input  wire logic [boqt_pkg::IN_BITS-1:0]  req_hi_y,
   input  wire logic [boqt_pkg::IN_BITS-1:0]  req_hi_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [boqt_pkg::SLOT_BITS-1:0]     rsp_slot,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_last
);
   import boqt_pkg::*;

   localparam int IDX_BITS = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

   cmd_type              cmd;
   stat_type             stat;
   logic [IDX_BITS-1:0]  wr_addr;
   logic [IDX_BITS-1:0]  rd_addr;
   logic [IDX_BITS-1:0]  slot_idx;

   boqt_ctrl #(
      .MAX_BOXES(MAX_BOXES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .cmd       (cmd),
      .stat      (stat),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .slot_idx  (slot_idx)
   );

   boqt_datapath #(
      .MAX_BOXES (MAX_BOXES),
      .COORD_BITS(COORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_lo_x   (req_lo_x),
      .req_lo_y   (req_lo_y),
      .req_lo_z   (req_lo_z),
      .req_hi_x   (req_hi_x),
      .req_hi_y   (req_hi_y),
      .req_hi_z   (req_hi_z),
      .cmd        (cmd),
      .stat       (stat),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .slot_idx   (slot_idx),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_slot   (rsp_slot),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

endmodule
`default_nettype wire
